@@ hdl/ttsp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttsp_pkg
// Shared types and constants for the transposition table store/probe unit.
// ----------------------------------------------------------------------------
package ttsp_pkg;

   // Slot count; a power of two, so the slot index is the low key bits.
   localparam int ENTRIES = 1024;
   localparam int IDX_W   = $clog2(ENTRIES);

   localparam int ACT_W   = 2;
   localparam int KEY_W   = 64;
   localparam int DEPTH_W = 7;
   localparam int SCORE_W = 16;
   localparam int KIND_W  = 2;

   localparam logic [ACT_W-1:0] ACT_PROBE = 2'd0;
   localparam logic [ACT_W-1:0] ACT_STORE = 2'd1;
   localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

   typedef struct packed {
      logic [KEY_W-1:0]          key;
      logic [DEPTH_W-1:0]        depth;
      logic signed [SCORE_W-1:0] score;
      logic                      ancient;
      logic [KIND_W-1:0]         kind;
   } ttsp_entry_type;

   // Controller to datapath.
   typedef struct packed {
      logic accept;
      logic sweep;
      logic commit;
   } ttsp_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic is_clear;
      logic sweep_last;
      logic out_free;
   } ttsp_sts_type;

endpackage

@@ hdl/ttsp_req_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttsp_req_if
// Request channel: valid/ready handshake with the probe/store/clear payload.
// ----------------------------------------------------------------------------
interface ttsp_req_if import ttsp_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [ACT_W-1:0]          action;
   logic [KEY_W-1:0]          key;
   logic [DEPTH_W-1:0]        search_depth;
   logic signed [SCORE_W-1:0] eval_score;
   logic                      is_ancient;
   logic [KIND_W-1:0]         node_kind;

   modport source (
      output valid, action, key, search_depth, eval_score, is_ancient, node_kind,
      input  ready
   );
   modport sink (
      input  valid, action, key, search_depth, eval_score, is_ancient, node_kind,
      output ready
   );
endinterface

@@ hdl/ttsp_rsp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttsp_rsp_if
// Response channel: valid/ready handshake with the lookup/store result.
// ----------------------------------------------------------------------------
interface ttsp_rsp_if import ttsp_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic                      hit;
   logic                      written;
   logic [KEY_W-1:0]          found_key;
   logic [DEPTH_W-1:0]        found_depth;
   logic signed [SCORE_W-1:0] found_score;
   logic                      found_ancient;
   logic [KIND_W-1:0]         found_kind;

   modport source (
      output valid, hit, written, found_key, found_depth, found_score,
             found_ancient, found_kind,
      input  ready
   );
   modport sink (
      input  valid, hit, written, found_key, found_depth, found_score,
             found_ancient, found_kind,
      output ready
   );
endinterface

@@ hdl/transposition_table_store_probe_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// transposition_table_store_probe_unit
// Direct-mapped transposition table with probe, conditional store and clear.
// ----------------------------------------------------------------------------
// One transaction is in flight at a time. A probe or store registers the slot
// RAM read at accept; the key compare, replacement decision and write-back
// follow in the look state, which waits until the result register is free.
// A clear sweeps the single RAM write port over all ENTRIES slots and returns
// its result once the sweep is done. After reset the same sweep runs over all
// ENTRIES (1024) slots with req_if.ready low. The result register lets the
// next request be accepted while a result still waits on rsp_if.ready.
// ----------------------------------------------------------------------------
module transposition_table_store_probe_unit import ttsp_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   ttsp_req_if.sink  req_if,
   ttsp_rsp_if.source rsp_if
);

   ttsp_cmd_type   cmd;
   ttsp_sts_type   sts;
   ttsp_entry_type found;

   ttsp_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   ttsp_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_action       (req_if.action),
      .req_key          (req_if.key),
      .req_search_depth (req_if.search_depth),
      .req_eval_score   (req_if.eval_score),
      .req_is_ancient   (req_if.is_ancient),
      .req_node_kind    (req_if.node_kind),
      .rsp_valid        (rsp_if.valid),
      .rsp_ready        (rsp_if.ready),
      .rsp_hit          (rsp_if.hit),
      .rsp_written      (rsp_if.written),
      .rsp_found        (found)
   );

   assign rsp_if.found_key     = found.key;
   assign rsp_if.found_depth   = found.depth;
   assign rsp_if.found_score   = found.score;
   assign rsp_if.found_ancient = found.ancient;
   assign rsp_if.found_kind    = found.kind;

endmodule

@@ hdl/ttsp_control.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttsp_control
// Sequencer: clearing sweeps, request accept, and result commit.
// ----------------------------------------------------------------------------
module ttsp_control import ttsp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  ttsp_sts_type sts,
   output ttsp_cmd_type cmd
);

   localparam logic [1:0] ST_INIT = 2'd0;
   localparam logic [1:0] ST_IDLE = 2'd1;
   localparam logic [1:0] ST_LOOK = 2'd2;
   localparam logic [1:0] ST_WIPE = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   assign req_ready  = (state_ff == ST_IDLE);
   assign cmd.accept = req_ready & req_valid;
   assign cmd.sweep  = (state_ff == ST_INIT) | (state_ff == ST_WIPE);
   assign cmd.commit = (state_ff == ST_LOOK) & sts.out_free;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT: begin
            if (sts.sweep_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (cmd.accept) state_in = sts.is_clear ? ST_WIPE : ST_LOOK;
         end
         ST_LOOK: begin
            if (sts.out_free) state_in = ST_IDLE;
         end
         ST_WIPE: begin
            if (sts.sweep_last) state_in = ST_LOOK;
         end
         default: state_in = ST_INIT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ hdl/ttsp_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttsp_datapath
// Slot memory, request latch, replacement decision and result register.
// ----------------------------------------------------------------------------
module ttsp_datapath import ttsp_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  ttsp_cmd_type              cmd,
   output ttsp_sts_type              sts,
   input  logic [ACT_W-1:0]          req_action,
   input  logic [KEY_W-1:0]          req_key,
   input  logic [DEPTH_W-1:0]        req_search_depth,
   input  logic signed [SCORE_W-1:0] req_eval_score,
   input  logic                      req_is_ancient,
   input  logic [KIND_W-1:0]         req_node_kind,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_hit,
   output logic                      rsp_written,
   output ttsp_entry_type            rsp_found
);

   ttsp_entry_type   mem_ff [ENTRIES];
   ttsp_entry_type   rd_ff;
   ttsp_entry_type   new_ff;
   logic [ACT_W-1:0] act_ff;
   logic [IDX_W-1:0] cnt_ff;
   logic             rsp_valid_ff;
   logic             hit_ff;
   logic             written_ff;
   ttsp_entry_type   found_ff;

   logic             take;
   logic             hit_in;
   logic             written_in;
   ttsp_entry_type   found_in;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   ttsp_entry_type   wr_data;

   assign sts.is_clear   = (req_action == ACT_CLEAR);
   assign sts.sweep_last = (cnt_ff == IDX_W'(ENTRIES - 1));
   assign sts.out_free   = ~rsp_valid_ff | rsp_ready;

   // Empty slot, non-ancient slot, or same key stored at a shallower depth.
   assign take = (rd_ff.key == '0) | ~rd_ff.ancient |
                 ((rd_ff.depth < new_ff.depth) & (rd_ff.key == new_ff.key));

   always_comb begin
      hit_in     = 1'b0;
      written_in = 1'b0;
      found_in   = '0;
      unique case (act_ff)
         ACT_PROBE: begin
            if (rd_ff.key == new_ff.key) begin
               hit_in   = 1'b1;
               found_in = rd_ff;
            end
         end
         ACT_STORE: written_in = take;
         default: ;
      endcase
   end

   assign wr_en   = cmd.sweep | (cmd.commit & written_in);
   assign wr_addr = cmd.sweep ? cnt_ff : new_ff.key[IDX_W-1:0];
   assign wr_data = cmd.sweep ? '0 : new_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      if (cmd.accept) rd_ff <= mem_ff[req_key[IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         act_ff          <= req_action;
         new_ff.key      <= req_key;
         new_ff.depth    <= req_search_depth;
         new_ff.score    <= req_eval_score;
         new_ff.ancient  <= req_is_ancient;
         new_ff.kind     <= req_node_kind;
      end
      if (cmd.commit) begin
         hit_ff     <= hit_in;
         written_ff <= written_in;
         found_ff   <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.sweep) cnt_ff <= cnt_ff + 1'b1;
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_hit     = hit_ff;
   assign rsp_written = written_ff;
   assign rsp_found   = found_ff;

endmodule

@@ hdl/ttsp_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttsp_checker
// Port-level checks for the transposition table unit, bound to the top level.
// ----------------------------------------------------------------------------
module ttsp_checker import ttsp_pkg::*; (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic                      rsp_hit,
   input logic                      rsp_written,
   input logic [KEY_W-1:0]          rsp_found_key,
   input logic [DEPTH_W-1:0]        rsp_found_depth,
   input logic signed [SCORE_W-1:0] rsp_found_score,
   input logic                      rsp_found_ancient,
   input logic [KIND_W-1:0]         rsp_found_kind
);

   // Single transaction in flight.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while another is in flight");

   // A miss reports all-zero entry fields.
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_hit) |-> (rsp_found_key == '0 && rsp_found_depth == '0 &&
         rsp_found_score == '0 && !rsp_found_ancient && rsp_found_kind == '0))
      else $error("miss with nonzero entry fields");

   // Hit and written never together.
   a_hit_xor_written: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_hit && rsp_written))
      else $error("result flags both hit and written");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_found_key) &&
         $stable(rsp_hit) && $stable(rsp_written)))
      else $error("stalled response changed");

endmodule

bind transposition_table_store_probe_unit ttsp_checker u_ttsp_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_if.valid),
   .req_ready         (req_if.ready),
   .rsp_valid         (rsp_if.valid),
   .rsp_ready         (rsp_if.ready),
   .rsp_hit           (rsp_if.hit),
   .rsp_written       (rsp_if.written),
   .rsp_found_key     (rsp_if.found_key),
   .rsp_found_depth   (rsp_if.found_depth),
   .rsp_found_score   (rsp_if.found_score),
   .rsp_found_ancient (rsp_if.found_ancient),
   .rsp_found_kind    (rsp_if.found_kind)
);
